### rtl/core/sws_pkg.sv
// Shared constants, types and the sine table builder for the sine wave sample generator.
// No dependencies; every other file in rtl/core imports this package.

package sws_pkg;

	// Field widths fixed by the register map and the result format
	localparam int unsigned LEVEL_W   = 12;
	localparam int unsigned INDEX_W   = 16;
	localparam int unsigned STEP_W    = 16;
	localparam int unsigned CFG_IDX_W = 4;
	localparam int unsigned CFG_DAT_W = 16;

	// Default datapath sizing
	localparam int unsigned DEF_PHASE_BITS      = 16;
	localparam int unsigned DEF_TABLE_ADDR_BITS = 10;
	localparam int unsigned DEF_SINE_BITS       = 16;

	typedef logic [LEVEL_W-1:0]   level_mv_t;
	typedef logic [INDEX_W-1:0]   sample_index_t;
	typedef logic [CFG_IDX_W-1:0] cfg_index_t;
	typedef logic [CFG_DAT_W-1:0] cfg_data_t;

	// Register indexes on the configuration channel
	localparam cfg_index_t REG_PHASE_STEP  = cfg_index_t'(0);
	localparam cfg_index_t REG_MIN_LEVEL   = cfg_index_t'(1);
	localparam cfg_index_t REG_MAX_LEVEL   = cfg_index_t'(2);
	localparam cfg_index_t REG_COUNT_LIMIT = cfg_index_t'(3);

	// Register reset values: 10 Hz at 500 samples/s, 1 V to 3 V, 5000 samples
	localparam logic [STEP_W-1:0]  RST_PHASE_STEP  = STEP_W'(1311);
	localparam level_mv_t          RST_MIN_LEVEL   = LEVEL_W'(1000);
	localparam level_mv_t          RST_MAX_LEVEL   = LEVEL_W'(3000);
	localparam sample_index_t      RST_COUNT_LIMIT = INDEX_W'(5000);

	// Q30 fixed point for the table builder
	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] Q30_HALF    = 64'd1 << 29;

	// Quarter-wave entry k: round(amp * sin(pi/2 * k / 2^qtr_shift)), sine by a
	// truncating Q30 Horner series up to the x^17 term. Elaboration time only.
	// Horner divisors run (2i)(2i+1) for i from 8 down to 1.
	function automatic logic [31:0] qtab_entry(input int unsigned k,
		input int unsigned qtr_shift, input int unsigned sine_bits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] amp;
		x  = (HALF_PI_Q30 * 64'(k)) >> qtr_shift;
		x2 = (x * x) >> 30;
		t  = Q30_ONE;
		t  = Q30_ONE - (((x2 * t) >> 30) / 64'd272);
		t  = Q30_ONE - (((x2 * t) >> 30) / 64'd210);
		t  = Q30_ONE - (((x2 * t) >> 30) / 64'd156);
		t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
		t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
		t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
		t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
		t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
		t = (x * t) >> 30;
		if (t > Q30_ONE) begin
			t = Q30_ONE;
		end
		amp = (64'd1 << (sine_bits - 1)) - 64'd1;
		return 32'((t * amp + Q30_HALF) >> 30);
	endfunction

endpackage

### rtl/core/sws_tick_if.sv
// Tick request channel of the sine wave sample generator: valid, ready, one tick bit.
// Depends on sws_pkg.

interface sws_tick_if;
	import sws_pkg::*;

	logic valid;
	logic ready;
	logic sample_tick;

	modport source (output valid, output sample_tick, input ready);
	modport sink (input valid, input sample_tick, output ready);
endinterface

### rtl/core/sws_sample_if.sv
// Result request channel of the sine wave sample generator: level and sample index.
// Depends on sws_pkg for the field types.

interface sws_sample_if;
	import sws_pkg::*;

	logic          valid;
	logic          ready;
	level_mv_t     level_mv;
	sample_index_t sample_index;

	modport source (output valid, output level_mv, output sample_index, input ready);
	modport sink (input valid, input level_mv, input sample_index, output ready);
endinterface

### rtl/core/sws_cfg_if.sv
// Configuration write channel of the sine wave sample generator: register index and data.
// Depends on sws_pkg for the field types.

interface sws_cfg_if;
	import sws_pkg::*;

	logic       valid;
	logic       ready;
	cfg_index_t index;
	cfg_data_t  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/sine_wave_sample_generator_unit.sv
// Top level of the sine wave sample generator: DDS phase accumulator, sine table, level scaling.
// Depends on sws_pkg and the interfaces sws_tick_if, sws_sample_if and sws_cfg_if.
//
// Usage
//   tick   : one request per sample period. sample_tick = 1 advances the sample counter
//            (wrapping to zero on reaching count_limit) and the phase accumulator by
//            phase_step; sample_tick = 0 is taken and dropped without any effect.
//   sample : one request per advancing tick, carrying level_mv = mid + half_span * sine (mV,
//            truncated toward zero) and the sample counter after that tick.
//   cfg    : register writes, always ready; index 0 phase_step, 1 min_level_mv,
//            2 max_level_mv, 3 count_limit, other indexes ignored. Write only while idle.
// Timing
//   A tick loads stage 1; the table read fills stage 2, the scaling multiply-add the
//   output register, which offers it on the sample channel. While tick ready is high
//   one tick is taken every cycle; the rate is set by the single phase add and the
//   three-register pipeline, each stage handing on one request per cycle.
// Reset and stall
//   arst_n clears the accumulator, the counter, the pipeline valids and loads the
//   register defaults (10 Hz at 500 samples/s, 1000 mV to 3000 mV, limit 5000).
//   When sample.ready is low the output holds; stages behind it keep filling, and tick
//   ready drops only once every stage holds a result.

module sine_wave_sample_generator_unit #(
	parameter int unsigned PHASE_BITS      = sws_pkg::DEF_PHASE_BITS,
	parameter int unsigned TABLE_ADDR_BITS = sws_pkg::DEF_TABLE_ADDR_BITS,
	parameter int unsigned SINE_BITS       = sws_pkg::DEF_SINE_BITS
) (
	input logic           clk,
	input logic           arst_n,
	sws_tick_if.sink      tick,
	sws_sample_if.source  sample,
	sws_cfg_if.sink       cfg
);
	import sws_pkg::*;

	localparam int unsigned QTR_BITS = TABLE_ADDR_BITS - 2;
	localparam int unsigned QTR_LEN  = 1 << QTR_BITS;
	// Scaled level: (max+min) << (SINE_BITS-1) plus a 13-bit by SINE_BITS product
	localparam int unsigned NUM_W    = SINE_BITS + 14;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [STEP_W-1:0] step_q;
	level_mv_t         min_q;
	level_mv_t         max_q;
	sample_index_t     limit_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= RST_PHASE_STEP;
			min_q   <= RST_MIN_LEVEL;
			max_q   <= RST_MAX_LEVEL;
			limit_q <= RST_COUNT_LIMIT;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PHASE_STEP:  step_q  <= cfg.data[STEP_W-1:0];
				REG_MIN_LEVEL:   min_q   <= cfg.data[LEVEL_W-1:0];
				REG_MAX_LEVEL:   max_q   <= cfg.data[LEVEL_W-1:0];
				REG_COUNT_LIMIT: limit_q <= cfg.data[INDEX_W-1:0];
				default: ; // drop writes to unused indexes
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Handshake: each stage takes a new request when empty or when it hands on
	// ------------------------------------------------------------------
	logic v_s1;
	logic v_s2;
	logic out_v_q;
	logic out_free;
	logic s2_free;
	logic s1_free;
	logic tick_take;
	logic s2_load;
	logic out_load;

	assign out_free  = !out_v_q || sample.ready;
	assign s2_free   = !v_s2 || out_free;
	assign s1_free   = !v_s1 || s2_free;
	assign tick.ready = s1_free;

	assign tick_take = tick.valid && tick.ready && tick.sample_tick;
	assign s2_load   = v_s1 && s2_free;
	assign out_load  = v_s2 && out_free;

	// ------------------------------------------------------------------
	// State: phase accumulator and sample counter, advanced per tick
	// ------------------------------------------------------------------
	logic [PHASE_BITS-1:0] phase_q;
	sample_index_t         count_q;
	logic [PHASE_BITS-1:0] phase_next;
	sample_index_t         count_inc;
	sample_index_t         count_next;

	assign phase_next = phase_q + PHASE_BITS'(step_q);
	assign count_inc  = count_q + INDEX_W'(1);
	// Return to zero at or above the limit; a limit of zero pins the counter at zero
	assign count_next = (count_inc >= limit_q) ? '0 : count_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			count_q <= '0;
		end else if (tick_take) begin
			phase_q <= phase_next;
			count_q <= count_next;
		end
	end

	// Stage 1 holds the new phase and counter of a tick
	logic [PHASE_BITS-1:0] phase_s1;
	sample_index_t         count_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_free) begin
			v_s1 <= tick_take;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_take) begin
			phase_s1 <= phase_next;
			count_s1 <= count_next;
		end
	end

	// ------------------------------------------------------------------
	// Sine lookup: top phase bits address a full wave folded onto a quarter table
	// ------------------------------------------------------------------
	logic [SINE_BITS-1:0] qtab [QTR_LEN+1];

	for (genvar k = 0; k <= QTR_LEN; k++) begin : g_qtab
		localparam logic [31:0] ENTRY = qtab_entry(k, QTR_BITS, SINE_BITS);
		assign qtab[k] = ENTRY[SINE_BITS-1:0];
	end

	logic [TABLE_ADDR_BITS-1:0] tab_addr;

	if (PHASE_BITS >= TABLE_ADDR_BITS) begin : g_addr_take
		assign tab_addr = phase_s1[PHASE_BITS-1 -: TABLE_ADDR_BITS];
	end else begin : g_addr_pad
		assign tab_addr = {phase_s1, {(TABLE_ADDR_BITS - PHASE_BITS){1'b0}}};
	end

	logic [1:0]                quad;
	logic [QTR_BITS-1:0]       idx_lo;
	logic [QTR_BITS:0]         tab_idx;
	logic [SINE_BITS-1:0]      mag;
	logic signed [SINE_BITS-1:0] sine_val;

	always_comb begin
		quad    = tab_addr[TABLE_ADDR_BITS-1 -: 2];
		idx_lo  = tab_addr[QTR_BITS-1:0];
		// Odd quadrants run the quarter table backwards
		tab_idx = quad[0] ? ((QTR_BITS + 1)'(QTR_LEN) - {1'b0, idx_lo}) : {1'b0, idx_lo};
		mag     = qtab[tab_idx];
		// Lower half-wave is the negated upper half
		sine_val = quad[1] ? -$signed(mag) : $signed(mag);
	end

	// Stage 2 holds the signed sine sample and the counter
	logic signed [SINE_BITS-1:0] sine_s2;
	sample_index_t               count_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			sine_s2  <= sine_val;
			count_s2 <= count_s1;
		end
	end

	// ------------------------------------------------------------------
	// Level scaling: ((max+min) << (SINE_BITS-1) + (max-min) * sine) >> SINE_BITS
	// ------------------------------------------------------------------
	logic [LEVEL_W:0]               lvl_sum;
	logic signed [LEVEL_W:0]        lvl_diff;
	logic signed [LEVEL_W+SINE_BITS:0] lvl_prod;
	logic signed [NUM_W-1:0]        lvl_base;
	logic signed [NUM_W-1:0]        lvl_num;
	level_mv_t                      level_val;

	always_comb begin
		lvl_sum  = {1'b0, max_q} + {1'b0, min_q};
		lvl_diff = $signed({1'b0, max_q}) - $signed({1'b0, min_q});
		lvl_prod = lvl_diff * sine_s2;
		lvl_base = $signed(NUM_W'({lvl_sum, {(SINE_BITS - 1){1'b0}}}));
		lvl_num  = lvl_base + NUM_W'(lvl_prod);
		// Clamp at zero, then keep the integer millivolts
		level_val = lvl_num[NUM_W-1] ? '0 : lvl_num[SINE_BITS +: LEVEL_W];
	end

	// Output register: holds its result while the receiver stalls
	level_mv_t     level_q;
	sample_index_t index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			level_q <= level_val;
			index_q <= count_s2;
		end
	end

	assign sample.valid        = out_v_q;
	assign sample.level_mv     = level_q;
	assign sample.sample_index = index_q;

`ifndef SYNTH
	// A tick always reaches stage 1
	a_tick_enters: assert property (@(posedge clk) disable iff (!arst_n)
		tick_take |=> v_s1)
		else $error("tick accepted but stage 1 not filled");

	// Phase advances by exactly the step on a tick
	a_phase_step: assert property (@(posedge clk) disable iff (!arst_n)
		tick_take |=> phase_q == PHASE_BITS'($past(phase_q) + PHASE_BITS'($past(step_q))))
		else $error("phase accumulator did not advance by the step");

	// Without a tick the state stays put
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!tick_take |=> $stable(phase_q) && $stable(count_q))
		else $error("state changed without a tick");

	// After a tick the counter is zero or below the limit in force
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		tick_take |=> count_q == '0 || count_q < $past(limit_q))
		else $error("sample counter not wrapped at the limit");

	// A blocked stage 2 result is never lost
	a_s2_keep: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !out_free |=> v_s2 && $stable(sine_s2) && $stable(count_s2))
		else $error("stage 2 result dropped under stall");
`endif

endmodule

### tb/sine_wave_sample_generator_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the sine wave sample generator: ticks, register writes, sample checks.
// Depends on sws_pkg, the tick, sample and cfg interfaces and sine_wave_sample_generator_unit.

module sine_wave_sample_generator_unit_tb;
	import sws_pkg::*;

	localparam int unsigned PHASE_W     = DEF_PHASE_BITS;
	localparam int unsigned ADDR_W      = DEF_TABLE_ADDR_BITS;
	localparam int unsigned SINE_W      = DEF_SINE_BITS;
	localparam int unsigned QTR_LEN     = 1 << (ADDR_W - 2);
	localparam longint unsigned ONE_Q30 = 64'd1 << 30;
	localparam longint unsigned PI_2Q30 = 64'd1686629713;

	// Index that decodes to no register; writes to it must leave everything alone
	localparam cfg_index_t REG_SPARE = cfg_index_t'(15);

	localparam int unsigned TICK_TARGET  = 1650;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned HOLD_CYCLES  = 60;
	localparam int unsigned CYCLE_LIMIT  = 400000;

	typedef struct packed {
		level_mv_t     level;
		sample_index_t index;
	} wave_sample_t;

	// Tracks the generator's registers, phase and counter, and queues the samples
	// that accepted ticks must produce, oldest first.
	class wave_level_tracker;
		int unsigned        quarter_wave [QTR_LEN + 1];
		logic [STEP_W-1:0]  step;
		level_mv_t          lo_mv;
		level_mv_t          hi_mv;
		sample_index_t      limit;
		logic [PHASE_W-1:0] phase;
		sample_index_t      count;
		wave_sample_t       pending_samples [$];
		int unsigned        mismatches;

		function new();
			longint unsigned x;
			longint unsigned x2;
			longint unsigned t;
			longint unsigned amp;
			amp = (64'd1 << (SINE_W - 1)) - 64'd1;
			// Quarter wave from a truncating Q30 Horner series up to x^17
			for (int unsigned k = 0; k <= QTR_LEN; k++) begin
				x  = (PI_2Q30 * 64'(k)) / 64'(QTR_LEN);
				x2 = (x * x) >> 30;
				t  = ONE_Q30;
				for (int i = 8; i >= 1; i--) begin
					t = ONE_Q30 - (((x2 * t) >> 30) / (64'(2 * i) * 64'(2 * i + 1)));
				end
				t = (x * t) >> 30;
				if (t > ONE_Q30) begin
					t = ONE_Q30;
				end
				quarter_wave[k] = int'((t * amp + (64'd1 << 29)) >> 30);
			end
			step        = RST_PHASE_STEP;
			lo_mv       = RST_MIN_LEVEL;
			hi_mv       = RST_MAX_LEVEL;
			limit       = RST_COUNT_LIMIT;
			phase       = '0;
			count       = '0;
			mismatches  = 0;
		endfunction

		function void set_reg(cfg_index_t idx, cfg_data_t val);
			case (idx)
				REG_PHASE_STEP:  step  = val;
				REG_MIN_LEVEL:   lo_mv = val[LEVEL_W-1:0];
				REG_MAX_LEVEL:   hi_mv = val[LEVEL_W-1:0];
				REG_COUNT_LIMIT: limit = val;
				default: ;
			endcase
		endfunction

		// Advance counter and phase, then queue the level for the new phase
		function void take_tick();
			int unsigned  addr;
			int unsigned  quad;
			int unsigned  slot;
			longint       sine;
			longint       num;
			wave_sample_t s;
			count = count + 1'b1;
			if (count >= limit) begin
				count = '0;
			end
			phase = phase + step;
			addr  = int'(phase) >> (PHASE_W - ADDR_W);
			quad  = (addr >> (ADDR_W - 2)) & 3;
			slot  = addr & (QTR_LEN - 1);
			if (quad[0]) begin
				slot = QTR_LEN - slot;
			end
			sine = longint'(quarter_wave[slot]);
			if (quad[1]) begin
				sine = -sine;
			end
			num = (longint'(hi_mv) + longint'(lo_mv)) * (longint'(1) << (SINE_W - 1))
				+ (longint'(hi_mv) - longint'(lo_mv)) * sine;
			if (num < 0) begin
				num = 0;
			end
			s.level = level_mv_t'(num >> SINE_W);
			s.index = count;
			pending_samples.push_back(s);
		endfunction

		function void check_sample(level_mv_t level, sample_index_t index);
			wave_sample_t e;
			if (pending_samples.size() == 0) begin
				$error("unexpected sample: level_mv %0d sample_index %0d", level, index);
				mismatches++;
				return;
			end
			e = pending_samples.pop_front();
			if (level !== e.level) begin
				$error("level_mv: expected %0d, actual %0d", e.level, level);
				mismatches++;
			end
			if (index !== e.index) begin
				$error("sample_index: expected %0d, actual %0d", e.index, index);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	sws_tick_if   tick_bus ();
	sws_sample_if sample_bus ();
	sws_cfg_if    cfg_bus ();

	sine_wave_sample_generator_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_bus),
		.sample (sample_bus),
		.cfg    (cfg_bus)
	);

	wave_level_tracker book = new();

	// Idling controls shared between the stimulus and the sample receiver
	bit          tx_gappy;
	bit          rx_gappy;
	bit          hold_req;
	int unsigned cycles;
	int unsigned ticks_sent;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Watchdog: a healthy run finishes far inside this many cycles
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("sine_wave_sample_generator_unit_tb NOT OK");
			$finish;
		end
	end

	// Outputs are sampled at the rising edge; ready is only ever moved at the falling edge
	always @(posedge clk) begin
		if (arst_n && sample_bus.valid && sample_bus.ready) begin
			book.check_sample(sample_bus.level_mv, sample_bus.sample_index);
		end
	end

	// Mostly short gaps, now and then a long one
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// Sample receiver: stalls at random, and on request holds ready low for a long
	// stretch so that the pipeline fills and the tick channel backs up.
	initial begin
		int unsigned stall;
		sample_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				sample_bus.ready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if (rx_gappy && $urandom_range(3) == 0) begin
				stall = 1 + gap_len();
				sample_bus.ready = 1'b0;
				repeat (stall - 1) @(negedge clk);
			end else begin
				sample_bus.ready = 1'b1;
			end
		end
	end

	// Offer one tick request and hold it until taken; returns at the next falling edge
	// with valid still high, so back-to-back requests keep it up without a dip.
	// Every accepted request counts towards the run length, idle ones included.
	task automatic send_tick(input logic t);
		tick_bus.valid       = 1'b1;
		tick_bus.sample_tick = t;
		do @(posedge clk); while (!tick_bus.ready);
		if (t) begin
			book.take_tick();
		end
		ticks_sent++;
		@(negedge clk);
	endtask

	task automatic idle_tx(input int unsigned n);
		if (n > 0) begin
			tick_bus.valid = 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// Drop valid, drain every queued sample, then let any idle request leave the pipe
	task automatic wait_idle();
		tick_bus.valid = 1'b0;
		while (book.pending_samples.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input cfg_data_t val);
		cfg_bus.valid = 1'b1;
		cfg_bus.index = idx;
		cfg_bus.data  = val;
		do @(posedge clk); while (!cfg_bus.ready);
		book.set_reg(idx, val);
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	initial begin
		int unsigned n_items;
		int unsigned r;
		int unsigned phase_no;
		logic        t;
		cfg_data_t   val;

		tick_bus.valid       = 1'b0;
		tick_bus.sample_tick = 1'b0;
		cfg_bus.valid        = 1'b0;
		cfg_bus.index        = REG_PHASE_STEP;
		cfg_bus.data         = '0;
		tx_gappy             = 1'b0;
		rx_gappy             = 1'b0;
		hold_req             = 1'b0;
		cycles               = 0;
		ticks_sent           = 0;
		arst_n               = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Register defaults, with idle requests mixed in that must leave no trace
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		wait_idle();

		// Widest span, phase stepping backwards, counter wrapping at two;
		// junk in the upper data bits of the level registers must be dropped
		write_reg(REG_PHASE_STEP, 16'hFFFF);
		write_reg(REG_MIN_LEVEL, 16'hF000);
		write_reg(REG_MAX_LEVEL, 16'h0FFF);
		write_reg(REG_COUNT_LIMIT, 16'd2);
		repeat (4) send_tick(1'b1);
		wait_idle();

		// Land the phase exactly on zero, then walk the four quadrant boundaries with
		// minimum above maximum and a zero limit that pins the counter at zero
		write_reg(REG_PHASE_STEP, cfg_data_t'(16'd0 - book.phase));
		send_tick(1'b1);
		wait_idle();
		write_reg(REG_PHASE_STEP, 16'd16384);
		write_reg(REG_MIN_LEVEL, 16'd4095);
		write_reg(REG_MAX_LEVEL, 16'd0);
		write_reg(REG_COUNT_LIMIT, 16'd0);
		write_reg(REG_SPARE, 16'hFFFF);
		repeat (4) send_tick(1'b1);
		wait_idle();

		// Frozen phase, flat wave, largest limit
		write_reg(REG_PHASE_STEP, 16'd0);
		write_reg(REG_MIN_LEVEL, 16'd2048);
		write_reg(REG_MAX_LEVEL, 16'd2048);
		write_reg(REG_COUNT_LIMIT, 16'hFFFF);
		repeat (2) send_tick(1'b1);
		wait_idle();

		// Half-turn steps on a zero span, limit of one
		write_reg(REG_PHASE_STEP, 16'd32768);
		write_reg(REG_MIN_LEVEL, 16'd0);
		write_reg(REG_MAX_LEVEL, 16'd0);
		write_reg(REG_COUNT_LIMIT, 16'd1);
		repeat (2) send_tick(1'b1);
		wait_idle();

		// Random phases: fresh settings, then a run of ticks with idle requests as noise
		phase_no = 0;
		while (ticks_sent < TICK_TARGET) begin
			r = $urandom_range(9);
			if (r == 0) begin
				val = $urandom_range(1) ? 16'hFFFF : 16'd0;
			end else if (r < 4) begin
				val = cfg_data_t'($urandom_range(1, 2000));
			end else begin
				val = cfg_data_t'($urandom_range(16'hFFFF));
			end
			write_reg(REG_PHASE_STEP, val);

			// Levels carry random upper bits; extremes now and then
			val = cfg_data_t'($urandom_range(16'hFFFF));
			if ($urandom_range(4) == 0) begin
				val[LEVEL_W-1:0] = $urandom_range(1) ? 12'hFFF : 12'h000;
			end
			write_reg(REG_MIN_LEVEL, val);
			val = cfg_data_t'($urandom_range(16'hFFFF));
			if ($urandom_range(4) == 0) begin
				val[LEVEL_W-1:0] = $urandom_range(1) ? 12'hFFF : 12'h000;
			end
			write_reg(REG_MAX_LEVEL, val);

			// Mostly short limits so the counter wraps often within a phase
			r = $urandom_range(9);
			if (r == 0) begin
				val = 16'd0;
			end else if (r == 1) begin
				val = cfg_data_t'($urandom_range(1, 3));
			end else if (r < 6) begin
				val = cfg_data_t'($urandom_range(1, 400));
			end else if (r < 9) begin
				val = cfg_data_t'($urandom_range(1, 16'hFFFF));
			end else begin
				val = 16'hFFFF;
			end
			write_reg(REG_COUNT_LIMIT, val);
			if ($urandom_range(5) == 0) begin
				write_reg(REG_SPARE, cfg_data_t'($urandom_range(16'hFFFF)));
			end

			tx_gappy = ($urandom_range(3) != 0);
			rx_gappy = ($urandom_range(3) != 0);
			// First phase: long receiver hold while ticks keep coming back to back
			if (phase_no == 0) begin
				tx_gappy = 1'b0;
				hold_req = 1'b1;
			end

			n_items = $urandom_range(100, 200);
			for (int unsigned k = 0; k < n_items; ) begin
				t = ($urandom_range(4) != 0);
				send_tick(t);
				if (t) begin
					k++;
				end
				// Second phase: hold the sender mid-way until the pipe has emptied
				if (phase_no == 1 && k == n_items / 2 && t) begin
					tick_bus.valid = 1'b0;
					while (book.pending_samples.size() != 0) @(negedge clk);
				end
				if (tx_gappy) begin
					idle_tx(gap_len());
				end
			end
			wait_idle();
			phase_no++;
		end

		rx_gappy = 1'b0;
		wait_idle();
		if (book.mismatches == 0) begin
			$display("sine_wave_sample_generator_unit_tb OK");
		end else begin
			$display("sine_wave_sample_generator_unit_tb NOT OK");
		end
		$finish;
	end

endmodule
